// ===== src/nkn_pkg.sv =====
// Package with the types, round constants and round functions of the Noekeon encryption pipeline.
`timescale 1ns / 1ps

package nkn_pkg;

   localparam int ROUND_COUNT_DEFAULT = 16;
   localparam int WORD_WIDTH          = 32;
   localparam int CSR_INDEX_WIDTH     = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD3 = 3'd3;

   typedef logic [3:0][WORD_WIDTH-1:0] nkn_state_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] plain_word0;
      logic [WORD_WIDTH-1:0] plain_word1;
      logic [WORD_WIDTH-1:0] plain_word2;
      logic [WORD_WIDTH-1:0] plain_word3;
   } nkn_req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] cipher_word0;
      logic [WORD_WIDTH-1:0] cipher_word1;
      logic [WORD_WIDTH-1:0] cipher_word2;
      logic [WORD_WIDTH-1:0] cipher_word3;
   } nkn_rsp_type;

   // Round constant table; entry ROUND_COUNT is used by the output stage.
   function automatic logic [7:0] nkn_round_const(input logic [4:0] idx);
      logic [7:0] rc;
      case (idx)
         5'd0:    rc = 8'h80;
         5'd1:    rc = 8'h1B;
         5'd2:    rc = 8'h36;
         5'd3:    rc = 8'h6C;
         5'd4:    rc = 8'hD8;
         5'd5:    rc = 8'hAB;
         5'd6:    rc = 8'h4D;
         5'd7:    rc = 8'h9A;
         5'd8:    rc = 8'h2F;
         5'd9:    rc = 8'h5E;
         5'd10:   rc = 8'hBC;
         5'd11:   rc = 8'h63;
         5'd12:   rc = 8'hC6;
         5'd13:   rc = 8'h97;
         5'd14:   rc = 8'h35;
         5'd15:   rc = 8'h6A;
         5'd16:   rc = 8'hD4;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] nkn_rol(input logic [WORD_WIDTH-1:0] x,
                                                     input int n);
      return (x << n) | (x >> (WORD_WIDTH - n));
   endfunction

   // Linear mixing layer with the working key folded in.
   function automatic nkn_state_type nkn_theta(input nkn_state_type w,
                                               input nkn_state_type key);
      nkn_state_type         s;
      logic [WORD_WIDTH-1:0] t;
      s = w;
      t = s[0] ^ s[2];
      t = t ^ nkn_rol(t, 8) ^ nkn_rol(t, 24);
      s[1] = s[1] ^ t;
      s[3] = s[3] ^ t;
      s = s ^ key;
      t = s[1] ^ s[3];
      t = t ^ nkn_rol(t, 8) ^ nkn_rol(t, 24);
      s[0] = s[0] ^ t;
      s[2] = s[2] ^ t;
      return s;
   endfunction

   // Rotations, the nonlinear layer with its word swap, and the inverse rotations.
   function automatic nkn_state_type nkn_pi_gamma_pi(input nkn_state_type w);
      logic [WORD_WIDTH-1:0] a0;
      logic [WORD_WIDTH-1:0] a1;
      logic [WORD_WIDTH-1:0] a2;
      logic [WORD_WIDTH-1:0] a3;
      logic [WORD_WIDTH-1:0] x;
      nkn_state_type         s;
      a0 = w[0];
      a1 = nkn_rol(w[1], 1);
      a2 = nkn_rol(w[2], 5);
      a3 = nkn_rol(w[3], 2);
      a1 = a1 ^ ~(a3 | a2);
      a0 = a0 ^ (a2 & a1);
      x  = a0;
      a0 = a3;
      a3 = x;
      a2 = a2 ^ a0 ^ a1 ^ a3;
      a1 = a1 ^ ~(a3 | a2);
      a0 = a0 ^ (a2 & a1);
      s[0] = a0;
      s[1] = nkn_rol(a1, 31);
      s[2] = nkn_rol(a2, 27);
      s[3] = nkn_rol(a3, 30);
      return s;
   endfunction

endpackage

// ===== src/nkn_stage.sv =====
// One register stage of the Noekeon pipeline: a full round, or the output transform.
`timescale 1ns / 1ps

module nkn_stage
   import nkn_pkg::*;
#(
   parameter bit LAST_STAGE = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    round_const,
   input  nkn_state_type key,
   input  logic          in_valid,
   output logic          in_ready,
   input  nkn_state_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output nkn_state_type out_data
);

   logic          valid_ff;
   logic          valid_in;
   nkn_state_type data_ff;
   nkn_state_type data_in;
   nkn_state_type mixed;

   // The stage takes a new item when empty or when its item leaves this cycle.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      mixed    = in_data;
      mixed[0] = in_data[0] ^ {{(WORD_WIDTH-8){1'b0}}, round_const};
      mixed    = nkn_theta(mixed, key);
      if (LAST_STAGE) begin
         data_in = mixed;
      end else begin
         data_in = nkn_pi_gamma_pi(mixed);
      end
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/noekeon_block_encrypt.sv =====
// Top level of the pipelined Noekeon direct-key block encryption.
`timescale 1ns / 1ps

// Noekeon encryption, direct-key mode, one 128-bit block per item.
//
// The key is written through the csr_ channel: index 0..3 selects key word
// 0..3, other indexes are ignored. csr_ready is always high. Write the key
// only while no item is in flight; every stage reads the key registers live.
//
// A plaintext item enters on the req_ channel and its ciphertext leaves on
// the rsp_ channel, both with valid/ready handshakes. The datapath is a
// chain of ROUND_COUNT + 1 register stages: one per round and one for the
// final constant XOR and Theta. One item can be accepted every cycle
// while the receiver does not stall.
//
// Each stage holds its own valid bit and ready is computed per stage, so
// when the receiver stalls the items close up behind the output register
// and req_ready stays high until every stage holds an item. Nothing is lost
// or repeated across a stall. Reset clears the key words to zero and empties
// every stage.

module noekeon_block_encrypt
   import nkn_pkg::*;
#(
   parameter int ROUND_COUNT = ROUND_COUNT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  nkn_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output nkn_rsp_type                rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_wdata
);

   localparam int STAGES = ROUND_COUNT + 1;

   nkn_state_type key_ff;
   nkn_state_type key_in;

   // Link k feeds stage k; link STAGES is the result channel.
   logic          link_valid [0:STAGES];
   logic          link_ready [0:STAGES];
   nkn_state_type link_data  [0:STAGES];
   logic [STAGES-1:0] stage_busy;

   // Key registers.
   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_WORD0: key_in[0] = csr_wdata;
            CSR_KEY_WORD1: key_in[1] = csr_wdata;
            CSR_KEY_WORD2: key_in[2] = csr_wdata;
            CSR_KEY_WORD3: key_in[3] = csr_wdata;
            default:       key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // The input words enter as state words 0..3.
   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];
   assign link_data[0]  = {req_data.plain_word3, req_data.plain_word2,
                           req_data.plain_word1, req_data.plain_word0};

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      nkn_stage #(
         .LAST_STAGE (k == ROUND_COUNT)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .round_const (nkn_round_const(5'(k))),
         .key         (key_ff),
         .in_valid    (link_valid[k]),
         .in_ready    (link_ready[k]),
         .in_data     (link_data[k]),
         .out_valid   (link_valid[k+1]),
         .out_ready   (link_ready[k+1]),
         .out_data    (link_data[k+1])
      );
      assign stage_busy[k] = link_valid[k+1];
   end

   // Result channel.
   assign link_ready[STAGES]  = rsp_ready;
   assign rsp_valid           = link_valid[STAGES];
   assign rsp_data.cipher_word0 = link_data[STAGES][0];
   assign rsp_data.cipher_word1 = link_data[STAGES][1];
   assign rsp_data.cipher_word2 = link_data[STAGES][2];
   assign rsp_data.cipher_word3 = link_data[STAGES][3];

   // A ready receiver lets every stage move, so the input side is open too.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low although the receiver is ready");

   // With every stage full and the receiver stalled, no item may enter.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&stage_busy) && !rsp_ready) |-> !req_ready)
      else $error("item accepted into a full stalled pipeline");

   // An empty stage never refuses an item.
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !stage_busy[0] |-> req_ready)
      else $error("empty first stage refused an item");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && stage_busy == '0))
      else $error("pipeline not empty after reset");

endmodule
